// ===== design/imd_pkg.sv =====
// Shared types and constants for the interval median-of-five decimator.
`timescale 1ns / 1ps

package imd_pkg;

   // Field widths of one sensor item.
   localparam int TEMP_W     = 15;
   localparam int HUMIDITY_W = 14;
   localparam int PRESSURE_W = 17;
   localparam int TICK_W     = 24;

   // Packed stream word, zero-filled to whole bytes.
   localparam int SAMPLE_BITS = 2 * TEMP_W + HUMIDITY_W + PRESSURE_W;
   localparam int TDATA_W     = ((SAMPLE_BITS + 7) / 8) * 8;

   // Register file.
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam logic REG_SAMPLE_INTERVAL = 1'b0;  // word index of sample_interval

   localparam logic [TICK_W-1:0] INTERVAL_RESET = TICK_W'(1000);
   localparam logic [TICK_W-1:0] TICK_MAX       = '1;

   localparam int SAMPLE_COUNT_DEFAULT = 5;
   localparam int QUEUE_DEPTH          = 2;

   typedef struct packed {
      logic [PRESSURE_W-1:0]   pressure;
      logic [HUMIDITY_W-1:0]   humidity;
      logic signed [TEMP_W-1:0] second_temperature;
      logic signed [TEMP_W-1:0] first_temperature;
   } sample_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [1:0] {
      BACK_FILL,
      BACK_SORT,
      BACK_HOLD
   } back_state_type;

endpackage

// ===== design/imd_front.sv =====
// Front end: tick counter that keeps or drops each incoming item.
`timescale 1ns / 1ps

module imd_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [imd_pkg::TICK_W-1:0]  sample_interval,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  imd_pkg::queue_status_type   queue_status,
   output logic                        push
);
   import imd_pkg::*;

   logic [TICK_W-1:0] elapsed_ff;
   logic [TICK_W-1:0] elapsed_in;
   logic [TICK_W-1:0] bumped;
   logic              accept;

   assign in_ready = ~queue_status.full;
   assign accept   = in_valid & in_ready;

   always_comb begin
      // saturating count
      bumped     = (elapsed_ff == TICK_MAX) ? elapsed_ff : elapsed_ff + TICK_W'(1);
      elapsed_in = elapsed_ff;
      push       = 1'b0;
      if (accept) begin
         if (bumped > sample_interval) begin
            elapsed_in = '0;
            push       = 1'b1;
         end else begin
            elapsed_in = bumped;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff <= '0;
      end else begin
         elapsed_ff <= elapsed_in;
      end
   end

endmodule

// ===== design/imd_queue.sv =====
// Short register queue between the front end and the sort engine.
`timescale 1ns / 1ps

module imd_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  imd_pkg::sample_type        push_data,
   input  logic                       pop,
   output imd_pkg::sample_type        pop_data,
   output imd_pkg::queue_status_type  status
);
   import imd_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   sample_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                do_push, do_pop;

   assign status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push & ~status.full;
   assign do_pop       = pop & ~status.empty;
   assign pop_data     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push & ~do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop & ~do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== design/imd_lane.sv =====
// One channel's slot store, sorted in place by odd-even transposition.
`timescale 1ns / 1ps

module imd_lane #(
   parameter int   WIDTH     = 16,
   parameter int   COUNT     = 5,
   parameter logic IS_SIGNED = 1'b0
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(COUNT)-1:0]   wr_slot,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic                       step_en,
   input  logic                       odd_phase,
   output logic [WIDTH-1:0]           median
);
   // flipping the sign bit turns a signed compare into an unsigned one
   localparam logic [WIDTH-1:0] FLIP = IS_SIGNED ? {1'b1, {(WIDTH-1){1'b0}}} : '0;

   logic [WIDTH-1:0] store_ff [COUNT];
   logic [WIDTH-1:0] store_in [COUNT];

   always_comb begin
      for (int k = 0; k < COUNT; k++) begin
         store_in[k] = store_ff[k];
      end
      if (wr_en) begin
         store_in[wr_slot] = wr_data;
      end
      if (step_en) begin
         for (int k = 0; k + 1 < COUNT; k++) begin
            if ((k[0] == odd_phase) &&
                ((store_ff[k] ^ FLIP) > (store_ff[k+1] ^ FLIP))) begin
               store_in[k]   = store_ff[k+1];
               store_in[k+1] = store_ff[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < COUNT; k++) begin
         store_ff[k] <= store_in[k];
      end
   end

   assign median = store_ff[COUNT/2];

endmodule

// ===== design/imd_back.sv =====
// Back end: fills the slot stores, runs the sort, holds the result.
`timescale 1ns / 1ps

module imd_back #(
   parameter int SAMPLE_COUNT = imd_pkg::SAMPLE_COUNT_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  imd_pkg::queue_status_type  queue_status,
   input  imd_pkg::sample_type        queue_data,
   output logic                       pop,
   output logic                       out_valid,
   input  logic                       out_ready,
   output imd_pkg::sample_type        out_data
);
   import imd_pkg::*;

   localparam int IDX_W = $clog2(SAMPLE_COUNT);

   back_state_type     state_ff, state_in;
   logic [IDX_W-1:0]   slot_ff, slot_in;
   logic [IDX_W-1:0]   phase_ff, phase_in;
   logic               out_valid_ff, out_valid_in;
   sample_type         out_data_ff;
   sample_type         median;
   logic               lane_wr, lane_step, load_out;
   logic               last_slot, last_phase;

   assign last_slot  = (slot_ff == IDX_W'(SAMPLE_COUNT - 1));
   assign last_phase = (phase_ff == IDX_W'(SAMPLE_COUNT - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BACK_FILL: begin
            if (!queue_status.empty && last_slot) state_in = BACK_SORT;
         end
         BACK_SORT: begin
            if (last_phase) state_in = BACK_HOLD;
         end
         BACK_HOLD: begin
            if (!out_valid_ff || out_ready) state_in = BACK_FILL;
         end
         default: state_in = BACK_FILL;
      endcase
   end

   // outputs
   always_comb begin
      lane_wr   = 1'b0;
      lane_step = 1'b0;
      load_out  = 1'b0;
      unique case (state_ff)
         BACK_FILL: lane_wr   = ~queue_status.empty;
         BACK_SORT: lane_step = 1'b1;
         BACK_HOLD: load_out  = ~out_valid_ff | out_ready;
         default: ;
      endcase
   end

   assign pop = lane_wr;

   always_comb begin
      slot_in      = slot_ff;
      phase_in     = phase_ff;
      out_valid_in = out_valid_ff;
      if (lane_wr) begin
         slot_in  = last_slot ? '0 : slot_ff + IDX_W'(1);
         phase_in = '0;
      end
      if (lane_step) begin
         phase_in = phase_ff + IDX_W'(1);
      end
      if (out_valid_ff && out_ready) begin
         out_valid_in = 1'b0;
      end
      if (load_out) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_FILL;
         slot_ff      <= '0;
         phase_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_data_ff <= median;
      end
   end

   imd_lane #(.WIDTH(TEMP_W), .COUNT(SAMPLE_COUNT), .IS_SIGNED(1'b1)) u_first (
      .clock     (clock),
      .wr_en     (lane_wr),
      .wr_slot   (slot_ff),
      .wr_data   (queue_data.first_temperature),
      .step_en   (lane_step),
      .odd_phase (phase_ff[0]),
      .median    (median.first_temperature)
   );

   imd_lane #(.WIDTH(TEMP_W), .COUNT(SAMPLE_COUNT), .IS_SIGNED(1'b1)) u_second (
      .clock     (clock),
      .wr_en     (lane_wr),
      .wr_slot   (slot_ff),
      .wr_data   (queue_data.second_temperature),
      .step_en   (lane_step),
      .odd_phase (phase_ff[0]),
      .median    (median.second_temperature)
   );

   imd_lane #(.WIDTH(HUMIDITY_W), .COUNT(SAMPLE_COUNT), .IS_SIGNED(1'b0)) u_humidity (
      .clock     (clock),
      .wr_en     (lane_wr),
      .wr_slot   (slot_ff),
      .wr_data   (queue_data.humidity),
      .step_en   (lane_step),
      .odd_phase (phase_ff[0]),
      .median    (median.humidity)
   );

   imd_lane #(.WIDTH(PRESSURE_W), .COUNT(SAMPLE_COUNT), .IS_SIGNED(1'b0)) u_pressure (
      .clock     (clock),
      .wr_en     (lane_wr),
      .wr_slot   (slot_ff),
      .wr_data   (queue_data.pressure),
      .step_en   (lane_step),
      .odd_phase (phase_ff[0]),
      .median    (median.pressure)
   );

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

// ===== design/interval_median_of_five_decimator.sv =====
// Top level of the interval median-of-five decimator.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake              Carries
//  req_      in         req_tvalid/req_tready  one tick with four sensor readings
//  rsp_      out        rsp_tvalid/rsp_tready  medians of the last SAMPLE_COUNT samples
//  csr_      in/out     APB, pready tied high  sample_interval at byte address 0
//
//  The front counter takes a tick whenever the queue is not full; kept ticks
//  go through a two-entry queue and are popped into the slot stores.
//  The tick that fills the last slot starts SAMPLE_COUNT odd-even sort
//  phases, then the medians enter the output register once it is free.
//  Reset (synchronous) clears the counter, the slot index and the queue; the
//  slot stores are not cleared. req_tready drops only while the queue is full,
//  which happens when the sort or a stalled result holds the back end.

module interval_median_of_five_decimator #(
   parameter int SAMPLE_COUNT = imd_pkg::SAMPLE_COUNT_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // req_tdata: first_temperature, second_temperature, humidity_sample,
   //            pressure_sample, zero pad (lowest bit up)
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [imd_pkg::TDATA_W-1:0]       req_tdata,
   // rsp_tdata: median_first_temperature, median_second_temperature,
   //            median_humidity, median_pressure, zero pad (lowest bit up)
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [imd_pkg::TDATA_W-1:0]       rsp_tdata,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [imd_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [imd_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [imd_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);
   import imd_pkg::*;

   logic [TICK_W-1:0]  interval_ff, interval_in;
   logic               csr_write;
   logic               reg_hit;
   logic               push;
   logic               pop;
   sample_type         req_sample;
   sample_type         queue_data;
   sample_type         rsp_sample;
   queue_status_type   queue_status;

   // ---------------- register port ----------------
   assign csr_pready = 1'b1;
   assign reg_hit    = (csr_paddr[2] == REG_SAMPLE_INTERVAL);
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      interval_in = interval_ff;
      // drop writes to any address beyond the one register
      if (csr_write && reg_hit) begin
         interval_in = csr_pwdata[TICK_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= INTERVAL_RESET;
      end else begin
         interval_ff <= interval_in;
      end
   end

   assign csr_prdata = reg_hit ? CSR_DATA_W'(interval_ff) : '0;

   // ---------------- payload unpack / pack ----------------
   assign req_sample = req_tdata[SAMPLE_BITS-1:0];
   assign rsp_tdata  = TDATA_W'(rsp_sample);

   // ---------------- front: count ticks, keep or drop ----------------
   imd_front u_front (
      .clock           (clock),
      .reset           (reset),
      .sample_interval (interval_ff),
      .in_valid        (req_tvalid),
      .in_ready        (req_tready),
      .queue_status    (queue_status),
      .push            (push)
   );

   // ---------------- queue between front and back ----------------
   imd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (req_sample),
      .pop       (pop),
      .pop_data  (queue_data),
      .status    (queue_status)
   );

   // ---------------- back: store, sort, emit medians ----------------
   imd_back #(.SAMPLE_COUNT(SAMPLE_COUNT)) u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_status (queue_status),
      .queue_data   (queue_data),
      .pop          (pop),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_data     (rsp_sample)
   );

endmodule

// ===== verif/tb_interval_median_of_five_decimator.sv =====
// Self-checking testbench for the interval median-of-five decimator.
`timescale 1ns / 1ps

module tb_interval_median_of_five_decimator;
   import imd_pkg::*;

   localparam int SAMPLE_COUNT    = SAMPLE_COUNT_DEFAULT;
   // Sort phases, output register and queue, with margin.
   localparam int SETTLE_CYCLES   = 4 * (SAMPLE_COUNT + 2 + QUEUE_DEPTH);
   localparam int RANDOM_PHASES   = 8;
   localparam int ITEMS_PER_PHASE = 50;

   localparam logic [CSR_ADDR_W-1:0] ADDR_SAMPLE_INTERVAL = CSR_ADDR_W'(4 * REG_SAMPLE_INTERVAL);
   localparam logic [CSR_ADDR_W-1:0] ADDR_UNMAPPED        = CSR_ADDR_W'(4);

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   // Tracks the slot stores and the tick counter, and holds the medians
   // that the block still owes.
   class median_scoreboard;
      logic [TICK_W-1:0] interval;
      logic [TICK_W-1:0] elapsed;
      int                slot;
      int                first_store[SAMPLE_COUNT];
      int                second_store[SAMPLE_COUNT];
      int                humidity_store[SAMPLE_COUNT];
      int                pressure_store[SAMPLE_COUNT];
      sample_type        pending_medians[$];
      int                errors;

      function new();
         interval = INTERVAL_RESET;
         elapsed  = '0;
         slot     = 0;
         errors   = 0;
      endfunction

      function void set_interval(logic [TICK_W-1:0] value);
         interval = value;
      endfunction

      static function int median_of(int vals[SAMPLE_COUNT]);
         int ranked[SAMPLE_COUNT];
         int key;
         int j;
         ranked = vals;
         for (int i = 1; i < SAMPLE_COUNT; i++) begin
            key = ranked[i];
            j = i - 1;
            while (j >= 0 && ranked[j] > key) begin
               ranked[j + 1] = ranked[j];
               j--;
            end
            ranked[j + 1] = key;
         end
         return ranked[SAMPLE_COUNT / 2];
      endfunction

      function void note_tick(sample_type s);
         sample_type m;
         if (elapsed != TICK_MAX) elapsed++;
         if (elapsed <= interval) return;
         elapsed = '0;
         first_store[slot]    = int'(s.first_temperature);
         second_store[slot]   = int'(s.second_temperature);
         humidity_store[slot] = int'(s.humidity);
         pressure_store[slot] = int'(s.pressure);
         slot++;
         if (slot < SAMPLE_COUNT) return;
         slot = 0;
         m.first_temperature  = TEMP_W'(median_of(first_store));
         m.second_temperature = TEMP_W'(median_of(second_store));
         m.humidity           = HUMIDITY_W'(median_of(humidity_store));
         m.pressure           = PRESSURE_W'(median_of(pressure_store));
         pending_medians.push_back(m);
      endfunction

      function void compare_field(string field, int want, int got);
         if (want != got) begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            errors++;
         end
      endfunction

      function void check_result(logic [TDATA_W-1:0] word);
         sample_type got;
         sample_type want;
         got = word[SAMPLE_BITS-1:0];
         compare_field("rsp_tdata pad", 0, int'(word[TDATA_W-1:SAMPLE_BITS]));
         if (pending_medians.size() == 0) begin
            $error("result with no median waiting: rsp_tdata %h", word);
            errors++;
            return;
         end
         want = pending_medians.pop_front();
         compare_field("median_first_temperature", int'(want.first_temperature),
                       int'(got.first_temperature));
         compare_field("median_second_temperature", int'(want.second_temperature),
                       int'(got.second_temperature));
         compare_field("median_humidity", int'(want.humidity), int'(got.humidity));
         compare_field("median_pressure", int'(want.pressure), int'(got.pressure));
      endfunction

      function int pending();
         return pending_medians.size();
      endfunction
   endclass

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [TDATA_W-1:0]    req_tdata   = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [TDATA_W-1:0]    rsp_tdata;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   idle_mode_type    idle_mode = IDLE_NONE;
   median_scoreboard board     = new();

   interval_median_of_five_decimator dut (.*);

   always #5 clock = ~clock;

   function automatic bit roll_idle(bit receiver_side);
      int pct;
      case (idle_mode)
         IDLE_NONE:     pct = 0;
         IDLE_SENDER:   pct = receiver_side ? 0 : 62;
         IDLE_RECEIVER: pct = receiver_side ? 62 : 0;
         default:       pct = 35;
      endcase
      return $urandom_range(0, 99) < pct;
   endfunction

   // Receiver side: stall at random, sample results at the rising edge.
   always @(negedge clock) rsp_tready <= !roll_idle(1'b1);

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_result(rsp_tdata);
   end

   function automatic sample_type make_sample(int ft, int st, int hum, int pres);
      sample_type s;
      s.first_temperature  = TEMP_W'(ft);
      s.second_temperature = TEMP_W'(st);
      s.humidity           = HUMIDITY_W'(hum);
      s.pressure           = PRESSURE_W'(pres);
      return s;
   endfunction

   // Mostly in-range readings; some raw bit patterns and some near-ties.
   function automatic sample_type random_sample();
      int ft;
      int st;
      int hum;
      int pres;
      case ($urandom_range(0, 9))
         0:       ft = $urandom();
         1:       ft = $urandom_range(0, 2) - 1;
         default: ft = $urandom_range(0, 12500) - 4000;
      endcase
      case ($urandom_range(0, 9))
         0:       st = $urandom();
         1:       st = $urandom_range(0, 2) - 1;
         default: st = $urandom_range(0, 12500) - 4000;
      endcase
      case ($urandom_range(0, 9))
         0:       hum = $urandom();
         1:       hum = $urandom_range(0, 2);
         default: hum = $urandom_range(0, 10000);
      endcase
      case ($urandom_range(0, 9))
         0:       pres = $urandom();
         1:       pres = 101325 + $urandom_range(0, 2);
         default: pres = $urandom_range(30000, 110000);
      endcase
      return make_sample(ft, st, hum, pres);
   endfunction

   task automatic send_tick(input sample_type s);
      @(negedge clock);
      while (roll_idle(1'b0)) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= TDATA_W'(s);
      do @(posedge clock); while (!req_tready);
      board.note_tick(s);
   endtask

   // Drop valid, wait out every owed median, then let the back end settle.
   task automatic drain();
      @(negedge clock) req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock) csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (addr == ADDR_SAMPLE_INTERVAL) board.set_interval(data[TICK_W-1:0]);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic csr_read_check(input logic [CSR_ADDR_W-1:0] addr,
                                 input logic [CSR_DATA_W-1:0] want);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= addr;
      @(negedge clock) csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== want) begin
         $error("sample_interval: expected %0d, actual %0d", want, csr_prdata);
         board.errors++;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic program_interval(input logic [TICK_W-1:0] value);
      csr_write(ADDR_SAMPLE_INTERVAL, CSR_DATA_W'(value));
      csr_read_check(ADDR_SAMPLE_INTERVAL, CSR_DATA_W'(value));
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Reset interval: one sample lands on the tick after the 1000th.
      csr_read_check(ADDR_SAMPLE_INTERVAL, CSR_DATA_W'(INTERVAL_RESET));
      repeat (int'(INTERVAL_RESET) + 1) send_tick(random_sample());
      drain();

      // Store on every tick; an unmapped write must leave the interval alone.
      program_interval('0);
      csr_write(ADDR_UNMAPPED, 32'h00FF_FFFF);
      csr_read_check(ADDR_SAMPLE_INTERVAL, '0);

      // Range ends, raw bit-pattern ends, zero.
      send_tick(make_sample(-4000, 8500, 0, 30000));
      send_tick(make_sample(8500, -4000, 10000, 110000));
      send_tick(make_sample(-16384, 16383, 16383, 131071));
      send_tick(make_sample(16383, -16384, 0, 0));
      send_tick(make_sample(0, 0, 0, 0));
      // All five slots equal.
      repeat (5) send_tick(make_sample(1234, -1234, 5000, 101325));
      // Ties around the median and sign crossings.
      send_tick(make_sample(-1, -1, 3, 50000));
      send_tick(make_sample(-1, 0, 3, 50000));
      send_tick(make_sample(1, -1, 3, 49999));
      send_tick(make_sample(1, 1, 2, 50001));
      send_tick(make_sample(0, 0, 3, 50000));
      // Strictly falling and rising channels.
      for (int k = 0; k < SAMPLE_COUNT; k++) begin
         send_tick(make_sample(8500 - 3000 * k, -4000 + 3000 * k,
                               10000 - 2500 * k, 110000 - 20000 * k));
      end
      drain();

      // Maximum interval: the saturated count never exceeds it.
      program_interval(TICK_MAX);
      repeat (5) send_tick(random_sample());
      drain();

      // Random phases, cycling through the idle modes.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         idle_mode = idle_mode_type'(phase % 4);
         case (phase)
            0, 3, 6: program_interval('0);
            1:       program_interval(TICK_W'(1));
            4:       program_interval(TICK_W'(2));
            5:       program_interval(TICK_W'($urandom_range(0, 7)));
            default: program_interval(TICK_W'($urandom_range(0, 3)));
         endcase
         repeat (ITEMS_PER_PHASE) send_tick(random_sample());
         drain();
      end

      if (board.errors == 0 && board.pending() == 0)
         $display("interval_median_of_five_decimator test passed");
      else
         $display("interval_median_of_five_decimator test failed");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("interval_median_of_five_decimator test failed");
      $finish;
   end

endmodule
